@@ rtl/core/lcdseq_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdseq_pkg;

   // Operation codes carried in the op field of a request beat
   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_CURSOR    = 3'd2,
      OP_CHAR      = 3'd3,
      OP_BACKLIGHT = 3'd4
   } op_type;

   // Where the nibble of a step comes from
   typedef enum logic [1:0] {
      NIB_CONST   = 2'b00,
      NIB_BYTE_HI = 2'b01,
      NIB_BYTE_LO = 2'b10
   } nib_sel_type;

   localparam int PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   // Program entry points and last step
   localparam pc_type PC_INIT      = 5'd0;
   localparam pc_type PC_CLEAR     = 5'd13;
   localparam pc_type PC_BYTE      = 5'd15;
   localparam pc_type PC_BACKLIGHT = 5'd17;
   localparam pc_type PC_LAST      = 5'd17;

   // One control word of the program
   typedef struct packed {
      nib_sel_type nib_sel;
      logic [3:0]  nib;
      logic        use_rs;   // take RS from the latched byte kind
      logic        strobe;
      logic [15:0] wait_us;
      logic        last;     // final step of the routine: halt
   } ucode_word_type;

   localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
   localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

endpackage : lcdseq_pkg

@@ rtl/core/char_lcd_nibble_sequencer.sv @@
// Top level: microcoded sequencer turning LCD commands into timed 4-bit bus writes.
`timescale 1ns / 1ps
//
//  channel   | dir | handshake           | content
//  ----------+-----+---------------------+----------------------------------------
//  req_*     | in  | tvalid/tready       | one display command per beat
//  rsp_*     | out | tvalid/tready/tlast | one bus write per beat, tlast ends cmd
//
//  A command is taken while the sequencer is idle; it then emits one result
//  per cycle, while the output is not stalled, from the microcode store
//  (init 13, clear 2, cursor 2, character 2, backlight 1) via the step counter.
//  A stalled result holds in the output register and freezes the step counter;
//  the next command may be taken while the final result still waits.
//  Synchronous active-high reset: idle, empty output, backlight off.
//  Undefined op codes are taken and dropped without results.

module char_lcd_nibble_sequencer
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // op[2:0], char_code[10:3], row[12:11], col[18:13], backlight_level[19], pad[23:20]
   input  logic [23:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reg_select[0], data_nibble[4:1], strobe_res[5], wait_us[21:6], backlight[22], pad[23]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type      state_ff, state_in;
   pc_type         pc_ff, pc_in;
   logic [7:0]     byte_ff, byte_in;      // byte for the shared byte routine
   logic           rs_ff, rs_in;          // RS level for the byte routine
   logic           backlight_ff, backlight_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [22:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   ucode_word_type word;
   logic           req_accept;
   logic           out_free;
   logic [3:0]     nibble;
   logic [2:0]     req_op;
   logic [7:0]     req_char;
   logic [1:0]     req_row;
   logic [5:0]     req_col;
   logic           req_bl;
   logic [6:0]     cursor_addr;

   assign req_op   = req_tdata[2:0];
   assign req_char = req_tdata[10:3];
   assign req_row  = req_tdata[12:11];
   assign req_col  = req_tdata[18:13];
   assign req_bl   = req_tdata[19];

   // DDRAM address wraps at 7 bits
   assign cursor_addr = {1'b0, req_col} + ROW_BASE[req_row];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   lcdseq_ucode_rom u_rom (
      .addr (pc_ff),
      .word (word)
   );

   always_comb begin
      unique case (word.nib_sel)
         NIB_BYTE_HI: nibble = byte_ff[7:4];
         NIB_BYTE_LO: nibble = byte_ff[3:0];
         default:     nibble = word.nib;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      byte_in       = byte_ff;
      rs_in         = rs_ff;
      backlight_in  = backlight_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // dispatch: jump to the routine's entry point
               unique case (req_op)
                  OP_INIT: begin
                     pc_in    = PC_INIT;
                     state_in = ST_RUN;
                  end
                  OP_CLEAR: begin
                     pc_in    = PC_CLEAR;
                     state_in = ST_RUN;
                  end
                  OP_CURSOR: begin
                     pc_in    = PC_BYTE;
                     byte_in  = CMD_DDRAM_ADDR | {1'b0, cursor_addr};
                     rs_in    = 1'b0;
                     state_in = ST_RUN;
                  end
                  OP_CHAR: begin
                     pc_in    = PC_BYTE;
                     byte_in  = req_char;
                     rs_in    = 1'b1;
                     state_in = ST_RUN;
                  end
                  OP_BACKLIGHT: begin
                     pc_in        = PC_BACKLIGHT;
                     backlight_in = req_bl;
                     state_in     = ST_RUN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {backlight_ff, word.wait_us, word.strobe, nibble,
                                word.use_rs & rs_ff};
               rsp_last_in   = word.last;
               if (word.last) begin
                  state_in = ST_IDLE;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= PC_INIT;
         backlight_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         backlight_ff  <= backlight_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rs_ff       <= rs_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // step counter never leaves the program while running
   a_pc_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= PC_LAST))
      else $error("step counter beyond program");

   // a free output register is always filled while a routine runs
   a_progress : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && !rsp_tvalid_ff) |=> rsp_tvalid_ff)
      else $error("sequencer stalled with free output");

   // backlight command updates the kept level
   a_backlight : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_BACKLIGHT)) |=> (backlight_ff == $past(req_bl)))
      else $error("backlight level not taken");
`endif

endmodule : char_lcd_nibble_sequencer

@@ rtl/core/lcdseq_ucode_rom.sv @@
// Microcode store: one control word per program step.
`timescale 1ns / 1ps

module lcdseq_ucode_rom
   import lcdseq_pkg::*;
(
   input  pc_type         addr,
   output ucode_word_type word
);

   function automatic ucode_word_type cw(nib_sel_type sel, logic [3:0] nib, logic use_rs,
                                         logic strobe, logic [15:0] wait_us, logic last);
      ucode_word_type w;
      w.nib_sel = sel;
      w.nib     = nib;
      w.use_rs  = use_rs;
      w.strobe  = strobe;
      w.wait_us = wait_us;
      w.last    = last;
      return w;
   endfunction

   always_comb begin
      unique case (addr)
         // init: power-on wait, reset nibbles, then 0x28 0x0C 0x01 0x06
         5'd0:    word = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, 16'd50000, 1'b0);
         5'd1:    word = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, 16'd5050,  1'b0);
         5'd2:    word = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, 16'd200,   1'b0);
         5'd3:    word = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, 16'd200,   1'b0);
         5'd4:    word = cw(NIB_CONST, 4'h2, 1'b0, 1'b1, 16'd200,   1'b0);
         5'd5:    word = cw(NIB_CONST, 4'h2, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd6:    word = cw(NIB_CONST, 4'h8, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd7:    word = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd8:    word = cw(NIB_CONST, 4'hC, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd9:    word = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd10:   word = cw(NIB_CONST, 4'h1, 1'b0, 1'b1, 16'd2050,  1'b0);
         5'd11:   word = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd12:   word = cw(NIB_CONST, 4'h6, 1'b0, 1'b1, 16'd50,    1'b1);
         // clear display
         5'd13:   word = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, 16'd50,    1'b0);
         5'd14:   word = cw(NIB_CONST, 4'h1, 1'b0, 1'b1, 16'd2050,  1'b1);
         // latched byte: cursor address or character
         5'd15:   word = cw(NIB_BYTE_HI, 4'h0, 1'b1, 1'b1, 16'd50,  1'b0);
         5'd16:   word = cw(NIB_BYTE_LO, 4'h0, 1'b1, 1'b1, 16'd50,  1'b1);
         // backlight change: zero-length wait carrying the new level
         5'd17:   word = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, 16'd0,     1'b1);
         default: word = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, 16'd0,     1'b1);
      endcase
   end

endmodule : lcdseq_ucode_rom
